>>> rtl/sha_pkg.sv
// shared types, constants and tables of the sha-256 byte stream hasher
package sha_pkg;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST  = 3'd7;

	// commands from the sequencer to the compression core
	typedef struct packed {
		logic       shift_en;
		logic [7:0] shift_byte;
		logic       start;
		logic       init;
	} sha_cmd_t;

	// status from the compression core
	typedef struct packed {
		logic busy;
	} sha_stat_t;

	function automatic logic [31:0] sha_iv(input logic [2:0] idx);
		logic [31:0] v;
		unique case (idx)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			3'd7: v = 32'h5be0cd19;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] sha_k(input logic [5:0] idx);
		logic [31:0] v;
		unique case (idx)
			6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
			6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
			6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
			6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
			6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
			6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
			6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
			6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
			6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
			6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
			6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
			6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
			6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
			6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
			6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
			6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
			6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
			6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
			6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
			6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
			6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
			6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
			6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
			6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
			6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
			6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
			6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
			6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
			6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
			6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
			6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
			6'd62: v = 32'hbef9a3f7; 6'd63: v = 32'hc67178f2;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/sha_core.sv
// sha-256 compression core: block window, one round per cycle, chaining words
module sha_core import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sha_cmd_t    cmd,
	input  logic [2:0]  rd_idx,
	output sha_stat_t   stat,
	output logic [31:0] rd_word
);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	logic [31:0] chain_q [8];
	logic [31:0] v_q     [8];
	logic [31:0] w_q     [16];
	logic [5:0]  round_q;
	logic        busy_q;
	logic        fin_q;

	logic [31:0] big0, big1, ch, maj, t1, t2, s0, s1, w_new;

	always_comb begin
		big1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + big1 + ch + sha_k(round_q) + w_q[0];
		big0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = big0 + maj;
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			round_q <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= sha_iv(3'(i));
		end else begin
			if (cmd.start) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == BLOCK_LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				fin_q <= 1'b0;
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
			end else if (cmd.init) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= sha_iv(3'(i));
			end
		end
	end

	// working variables and message window
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
		end else if (busy_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (busy_q) begin
			for (int j = 0; j < 15; j++) w_q[j] <= w_q[j + 1];
			w_q[15] <= w_new;
		end else if (cmd.shift_en) begin
			// bytes enter at the bottom, first byte ends up in the top of word 0
			for (int j = 0; j < 15; j++) w_q[j] <= {w_q[j][23:0], w_q[j + 1][31:24]};
			w_q[15] <= {w_q[15][23:0], cmd.shift_byte};
		end
	end

	assign stat.busy = busy_q | fin_q;
	assign rd_word   = chain_q[rd_idx];

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
// top level of the sha-256 byte stream hasher: byte intake, padding sequencer, digest output
//
// usage
// - input channel (in_valid / in_ready) carries one item: data_byte, byte_valid and
//   end_of_message; an item with byte_valid low adds no byte, end_of_message closes
//   the message after this item's byte
// - output channel (out_valid / out_ready) carries the digest as eight items,
//   digest_word big-endian, word_index 0 to 7, last_word high on the eighth
// - an item that neither fills the 64-byte block nor ends the message keeps in_ready high
// - the item that fills a block holds off in_ready while the round unit runs its 64 rounds,
//   the words are folded into the chain and the sequencer returns to intake
// - end of message shifts the pad byte, zero fill and the 8 length bytes through the
//   block window one byte per cycle, runs the compression of each block (one or two
//   blocks), then presents the eight words one per accepted item
// - in_ready stays low from end of message until the eighth word is taken; a stall on
//   out_ready simply holds the current word, nothing is lost
// - reset clears the length count and fill count and loads the standard initial hash;
//   block window contents are not reset, every byte is written before it is used
// - the byte counter wraps, so the bit length used in padding wraps modulo 2^64
module sha256_byte_stream_hasher import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAD  = 2'd1;
	localparam logic [1:0] ST_COMP = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]  state_q, after_q;
	logic [5:0]  fill_q;
	logic [60:0] byte_cnt_q;   // message length in bytes, bit length is this times 8
	logic [63:0] len_q;        // bit length latched at end of message
	logic        pad_first_q;  // next pad byte is the 0x80 marker
	logic        extra_q;      // marker landed in the length field, block needs no length
	logic [2:0]  idx_q;

	sha_cmd_t    cmd;
	sha_stat_t   stat;
	logic [31:0] rd_word;

	logic        in_acc, out_acc;
	logic        in_full;
	logic        pad_tail;     // pad position inside the length field
	logic        extra_now;
	logic [2:0]  len_k;
	logic [7:0]  pad_byte;
	logic [60:0] byte_cnt_nx;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc   = out_valid & out_ready;

	assign in_full     = byte_valid & (fill_q == BLOCK_LAST);
	assign byte_cnt_nx = byte_cnt_q + {60'd0, byte_valid};
	assign pad_tail    = (fill_q >= LEN_POS);
	assign extra_now   = extra_q | (pad_first_q & pad_tail);
	assign len_k       = WORD_LAST - fill_q[2:0];

	always_comb begin
		priority if (pad_first_q)
			pad_byte = PAD_BYTE;
		else if (pad_tail && !extra_q)
			pad_byte = len_q[{len_k, 3'b000} +: 8];
		else
			pad_byte = 8'h00;
	end

	// commands to the core
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.shift_en   = in_acc & byte_valid;
				cmd.shift_byte = data_byte;
				cmd.start      = in_acc & in_full;
			end
			ST_PAD: begin
				cmd.shift_en   = 1'b1;
				cmd.shift_byte = pad_byte;
				cmd.start      = (fill_q == BLOCK_LAST);
			end
			ST_COMP: begin
			end
			ST_OUT: begin
				cmd.init = out_acc & (idx_q == WORD_LAST);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			after_q     <= ST_IDLE;
			fill_q      <= '0;
			byte_cnt_q  <= '0;
			pad_first_q <= 1'b0;
			extra_q     <= 1'b0;
			idx_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (byte_valid) begin
							fill_q     <= fill_q + 6'd1;
							byte_cnt_q <= byte_cnt_nx;
						end
						if (end_of_message) begin
							pad_first_q <= 1'b1;
							extra_q     <= 1'b0;
						end
						if (in_full) begin
							state_q <= ST_COMP;
							after_q <= end_of_message ? ST_PAD : ST_IDLE;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q      <= fill_q + 6'd1;
					pad_first_q <= 1'b0;
					if (fill_q == BLOCK_LAST) begin
						// block complete: compress, then more padding or the digest
						extra_q <= 1'b0;
						state_q <= ST_COMP;
						after_q <= extra_now ? ST_PAD : ST_OUT;
					end else begin
						extra_q <= extra_now;
					end
				end
				ST_COMP: begin
					if (!stat.busy) state_q <= after_q;
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == WORD_LAST) begin
							state_q    <= ST_IDLE;
							byte_cnt_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bit length, latched with the closing item
	always_ff @(posedge clk) begin
		if (in_acc && end_of_message) len_q <= {byte_cnt_nx, 3'b000};
	end

	sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_idx  (idx_q),
		.stat    (stat),
		.rd_word (rd_word)
	);

	assign digest_word = rd_word;
	assign word_index  = idx_q;
	assign last_word   = (idx_q == WORD_LAST);

endmodule

>>> dv/tb_sha256_byte_stream_hasher.sv
// self-checking testbench of the sha-256 byte stream hasher with a built-in digest predictor
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher;

	// run control
	localparam int STALL_LIMIT  = 4000;  // cycles with no item moving on either channel
	localparam int DRAIN_CYCLES = 300;   // quiet tail, covers padding plus two compressions
	localparam int ITEM_TARGET  = 200;   // message items in the random part
	localparam int IDLE_PCT     = 24;    // chance of an idle cycle on each side

	// sha-256 framing
	localparam logic [7:0] PAD_MARK    = 8'h80;
	localparam int         BLOCK_SIZE  = 64;
	localparam int         LENGTH_SLOT = 56;

	// well-known digests, readable at a glance
	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// message lengths around the padding boundaries: pad fits, pad spills, full block
	localparam int EDGE_LENS [4] = '{55, 56, 64, 63};

	// one row of the directed table; a known digest overrides the predictor
	typedef struct packed {
		logic [7:0]   data;
		logic         has_byte;
		logic         ends;
		logic         known;
		logic [255:0] digest;
	} dir_row_t;

	localparam int DIR_COUNT = 12;
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message, end with no byte
		'{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // end carried on the last byte
		'{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},        // no byte, no end: ignored
		'{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},        // lowest byte value
		'{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},        // payload present but not flagged
		'{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},        // highest byte value
		'{8'h5a, 1'b0, 1'b1, 1'b0, 256'h0},        // end after bytes already held
		'{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty again, chain restarted
		'{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
		'{8'hff, 1'b1, 1'b1, 1'b0, 256'h0}
	};

	// one digest word as it should leave the block
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// predictor state
	logic [31:0] chain_h [8];
	logic [7:0]  blk_buf [BLOCK_SIZE];
	int          fill_n;
	logic [63:0] bit_len;
	logic [31:0] digest_out [8];

	digest_item_t expected_words [$];
	int           fail_cnt;
	int           stall_cycles;
	bit           calm;  // suppresses idling on both sides

	sha256_byte_stream_hasher i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// restart the chain at the standard initial hash
	task automatic restart_hash();
		for (int i = 0; i < 8; i++) chain_h[i] = START_HASH[i];
		fill_n  = 0;
		bit_len = 64'd0;
	endtask

	// 64 rounds over the buffered block, folded into the chain
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++) v[i] = chain_h[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
	endtask

	// advance the predictor by one accepted item; done flags a finished digest
	task automatic absorb_item(input logic [7:0] d, input logic bv, input logic eom,
		output bit done);
		logic [63:0] total;
		done = 1'b0;
		if (bv) begin
			blk_buf[fill_n] = d;
			fill_n++;
			if (fill_n >= BLOCK_SIZE) begin
				compress_block();
				bit_len = bit_len + 64'd512;
				fill_n  = 0;
			end
		end
		if (eom) begin
			// length wraps modulo 2^64 by the width of the sum
			total = bit_len + 64'(fill_n) * 64'd8;
			blk_buf[fill_n] = PAD_MARK;
			fill_n++;
			// no room for the length: close this block and pad a fresh one
			if (fill_n > LENGTH_SLOT) begin
				while (fill_n < BLOCK_SIZE) begin
					blk_buf[fill_n] = 8'h00;
					fill_n++;
				end
				compress_block();
				fill_n = 0;
			end
			while (fill_n < LENGTH_SLOT) begin
				blk_buf[fill_n] = 8'h00;
				fill_n++;
			end
			for (int i = 0; i < 8; i++) blk_buf[LENGTH_SLOT+i] = total[63-8*i -: 8];
			compress_block();
			for (int i = 0; i < 8; i++) digest_out[i] = chain_h[i];
			done = 1'b1;
			restart_hash();
		end
	endtask

	// offer one item, hold it until taken, then log the digest words it causes
	task automatic send_item(input logic [7:0] d, input logic bv, input logic eom,
		input logic known, input logic [255:0] known_digest);
		bit           done;
		digest_item_t exp_w;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= d;
		byte_valid     <= bv;
		end_of_message <= eom;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		absorb_item(d, bv, eom, done);
		if (done) begin
			for (int k = 0; k < 8; k++) begin
				exp_w.word = known ? known_digest[255-32*k -: 32] : digest_out[k];
				exp_w.idx  = 3'(k);
				exp_w.last = (k == 7);
				expected_words.push_back(exp_w);
			end
		end
	endtask

	// sender holds off until every digest word already owed has arrived
	task automatic wait_digest_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
	endtask

	// receiver: random back-pressure, none during the calm stretch
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// digest word checker
	always @(posedge clk) begin
		digest_item_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: digest word %h with nothing expected", $time, digest_word);
				fail_cnt++;
			end else begin
				exp_w = expected_words.pop_front();
				if (digest_word !== exp_w.word) begin
					$display("%0t: digest_word expected %h got %h",
						$time, exp_w.word, digest_word);
					fail_cnt++;
				end
				if (word_index !== exp_w.idx) begin
					$display("%0t: word_index expected %0d got %0d",
						$time, exp_w.idx, word_index);
					fail_cnt++;
				end
				if (last_word !== exp_w.last) begin
					$display("%0t: last_word expected %0b got %0b",
						$time, exp_w.last, last_word);
					fail_cnt++;
				end
			end
		end
	end

	// count cycles in which no item moves on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	// watchdog
	initial begin
		stall_cycles = 0;
		@(posedge clk);
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("[sha256_byte_stream_hasher] ERROR");
		$finish;
	end

	// main sequence
	initial begin
		int items;
		int msg;
		int len;
		bit sep_end;
		fail_cnt       = 0;
		calm           = 1'b0;
		in_valid       = 1'b0;
		data_byte      = 8'h00;
		byte_valid     = 1'b0;
		end_of_message = 1'b0;
		arst_n         = 1'b0;
		restart_hash();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int r = 0; r < DIR_COUNT; r++)
			send_item(DIR_ROWS[r].data, DIR_ROWS[r].has_byte, DIR_ROWS[r].ends,
				DIR_ROWS[r].known, DIR_ROWS[r].digest);
		wait_digest_drain();

		// random messages, every third one at a padding boundary
		items = 0;
		msg   = 0;
		while (items < ITEM_TARGET) begin
			if (msg % 3 == 1)
				len = EDGE_LENS[(msg / 3) % 4];
			else
				len = $urandom_range(0, 12);
			calm    = (msg >= 2 && msg < 5);
			sep_end = (len == 0) || ($urandom_range(0, 1) == 1);
			for (int i = 0; i < len; i++) begin
				// occasional empty item inside the message
				if ($urandom_range(0, 9) == 0)
					send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 256'h0);
				send_item(8'($urandom_range(0, 255)), 1'b1,
					(i == len - 1) && !sep_end, 1'b0, 256'h0);
				items++;
			end
			if (sep_end) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 256'h0);
				items++;
			end
			if ($urandom_range(0, 3) == 0) wait_digest_drain();
			msg++;
		end
		calm = 1'b0;

		// wind down: all words in, then a quiet tail for strays
		wait_digest_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("[sha256_byte_stream_hasher] OK");
		else
			$display("[sha256_byte_stream_hasher] ERROR");
		$finish;
	end

endmodule
